// ===== src/hsc_pkg.sv =====
// Package with the transfer types, command codes and Hangul constants of the syllable codec.
package hsc_pkg;

  typedef enum logic [1:0] {
    CMD_FULL    = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_COMPOSE = 2'd2,
    CMD_NONE    = 2'd3
  } hsc_cmd_t;

  typedef struct packed {
    hsc_cmd_t    cmd;
    logic [20:0] code_a;
    logic [20:0] code_b;
  } hsc_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        matched;
    logic        last;
  } hsc_result_t;

  // One decoded item: how many results it gives and their code points in order.
  typedef struct packed {
    logic [1:0]       cnt;
    logic             matched;
    logic [2:0][20:0] code;
  } hsc_bundle_t;

  localparam logic [20:0] S_BASE = 21'h00AC00;
  localparam logic [20:0] S_LAST = 21'h00D7A3;
  localparam logic [20:0] L_BASE = 21'h001100;
  localparam logic [20:0] L_END  = 21'h001113;
  localparam logic [20:0] V_BASE = 21'h001161;
  localparam logic [20:0] V_END  = 21'h001176;
  localparam logic [20:0] T_BASE = 21'h0011A7;
  localparam logic [20:0] T_END  = 21'h0011C3;

  localparam int unsigned V_COUNT = 21;
  localparam int unsigned T_COUNT = 28;

  // Reciprocals rounded up, exact over the syllable index range.
  localparam logic [26:0] RECIP_T = 27'd9363;
  localparam int unsigned RECIP_T_SHIFT = 18;
  localparam logic [18:0] RECIP_V = 19'd781;
  localparam int unsigned RECIP_V_SHIFT = 14;

endpackage

// ===== src/hsc_datapath.sv =====
// Four-stage arithmetic pipeline that splits or joins syllables and builds the result bundle.
module hsc_datapath
  import hsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  hsc_item_t   item,
  output logic        res_valid,
  input  logic        res_stall,
  output hsc_bundle_t res
);

  typedef struct packed {
    hsc_cmd_t    cmd;
    logic [20:0] a;
    logic        syl;
    logic        lv_ok;
    logic        t_ok;
    logic [4:0]  tb;
    logic [4:0]  li;
    logic [4:0]  vi;
    logic [13:0] s;
    logic [8:0]  q;
    logic [8:0]  n;
    logic [4:0]  t;
    logic [4:0]  l;
    logic [20:0] comp_lv;
  } hsc_stage_t;

  hsc_stage_t  st1, st2, st3;
  hsc_stage_t  st1_next, st2_next, st3_next;
  hsc_bundle_t st4_next;
  logic        v1, v2, v3, v4;
  logic        rdy1, rdy2, rdy3, rdy4;
  logic [26:0] prod_q;
  logic [18:0] prod_l;
  logic [4:0]  v_idx;

  assign rdy4 = !v4 || !res_stall;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign item_stall = !rdy1;
  assign res_valid  = v4;

  always_comb begin
    st1_next       = '0;
    st1_next.cmd   = item.cmd;
    st1_next.a     = item.code_a;
    st1_next.syl   = (item.code_a >= S_BASE) && (item.code_a <= S_LAST);
    st1_next.lv_ok = (item.code_a >= L_BASE) && (item.code_a < L_END) &&
                     (item.code_b >= V_BASE) && (item.code_b < V_END);
    st1_next.t_ok  = (item.code_b > T_BASE) && (item.code_b < T_END);
    st1_next.tb    = 5'(item.code_b - T_BASE);
    st1_next.li    = 5'(item.code_a - L_BASE);
    st1_next.vi    = 5'(item.code_b - V_BASE);
    st1_next.s     = 14'(item.code_a - S_BASE);
  end

  assign prod_q = 27'(st1.s) * RECIP_T;

  always_comb begin
    st2_next   = st1;
    st2_next.q = prod_q[RECIP_T_SHIFT +: 9];
    st2_next.n = 9'(9'(st1.li) * 9'(V_COUNT) + 9'(st1.vi));
  end

  assign prod_l = 19'(st2.q) * RECIP_V;

  always_comb begin
    st3_next         = st2;
    st3_next.t       = 5'(st2.s - 14'(st2.q) * 14'(T_COUNT));
    st3_next.l       = prod_l[RECIP_V_SHIFT +: 5];
    st3_next.comp_lv = 21'(21'(st2.n) * 21'(T_COUNT)) + S_BASE;
  end

  assign v_idx = 5'(st3.q - 9'(st3.l) * 9'(V_COUNT));

  always_comb begin
    st4_next         = '0;
    st4_next.cnt     = 2'd1;
    st4_next.matched = 1'b0;
    unique case (st3.cmd)
      CMD_FULL: begin
        if (st3.syl) begin
          st4_next.cnt     = (st3.t != 5'd0) ? 2'd3 : 2'd2;
          st4_next.matched = 1'b1;
          st4_next.code[0] = L_BASE + 21'(st3.l);
          st4_next.code[1] = V_BASE + 21'(v_idx);
          st4_next.code[2] = T_BASE + 21'(st3.t);
        end else begin
          st4_next.code[0] = st3.a;
        end
      end
      CMD_STEP: begin
        st4_next.cnt = 2'd2;
        if (st3.syl) begin
          st4_next.matched = 1'b1;
          if (st3.t != 5'd0) begin
            st4_next.code[0] = st3.a - 21'(st3.t);
            st4_next.code[1] = T_BASE + 21'(st3.t);
          end else begin
            st4_next.code[0] = L_BASE + 21'(st3.l);
            st4_next.code[1] = V_BASE + 21'(v_idx);
          end
        end else begin
          st4_next.code[0] = st3.a;
        end
      end
      CMD_COMPOSE: begin
        if (st3.lv_ok) begin
          st4_next.matched = 1'b1;
          st4_next.code[0] = st3.comp_lv;
        end else if (st3.syl && (st3.t == 5'd0) && st3.t_ok) begin
          st4_next.matched = 1'b1;
          st4_next.code[0] = st3.a + 21'(st3.tb);
        end
      end
      CMD_NONE: begin
        st4_next.cnt = 2'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= item_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) st1 <= st1_next;
    if (rdy2) st2 <= st2_next;
    if (rdy3) st3 <= st3_next;
    if (rdy4) res <= st4_next;
  end

endmodule

// ===== src/hsc_serializer.sv =====
// Output stage that sends the one to three code points of each bundle as separate transfers.
module hsc_serializer
  import hsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  output logic        res_stall,
  input  hsc_bundle_t res,
  output logic        result_valid,
  input  logic        result_stall,
  output hsc_result_t result
);

  hsc_bundle_t hold;
  logic        busy;
  logic [1:0]  idx;
  logic        is_last;
  logic        take;

  assign is_last = (idx == 2'(hold.cnt - 2'd1));
  assign take    = !busy || (!result_stall && is_last);
  assign res_stall = !take;

  assign result_valid      = busy;
  assign result.code_point = hold.code[idx];
  assign result.matched    = hold.matched;
  assign result.last       = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (take) begin
      busy <= res_valid;
      idx  <= 2'd0;
    end else if (!result_stall) begin
      idx <= 2'(idx + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) hold <= res;
  end

`ifndef ASSERT_OFF
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> hold.cnt != 2'd0)
    else $error("bundle held with zero results");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx < hold.cnt)
    else $error("result index past bundle count");

  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    busy && result_stall |=> busy && idx == $past(idx))
    else $error("result index moved while stalled");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    busy && !result_stall && !is_last |=> busy && idx == 2'($past(idx) + 2'd1))
    else $error("bundle left before its last transfer");
`endif

endmodule

// ===== src/hangul_syllable_codec.sv =====
// Top level of the Hangul syllable codec: arithmetic pipeline followed by the output serializer.
//
//  channel   valid         stall          payload
//  input     item_valid    item_stall     item   (hsc_item_t: cmd, code_a, code_b)
//  output    result_valid  result_stall   result (hsc_result_t: code_point, matched, last)
//
// An item enters every cycle while the output keeps pace; the first result of an item passes
// through the four pipeline stages and the output register.
// The output sends one code point per cycle while result_stall is low, so an item holds the
// output for one to three transfers and that number sets the sustained rate.
// Reset clears all valid bits and the serializer; no clearing pass is needed.
// A stall on the output backs up stage by stage without loss or repetition.
module hangul_syllable_codec
  import hsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  hsc_item_t   item,
  output logic        result_valid,
  input  logic        result_stall,
  output hsc_result_t result
);

  hsc_bundle_t res;
  logic        res_valid;
  logic        res_stall;

  hsc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  hsc_serializer u_serializer (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res          (res),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== bench/hsc_checker.sv =====
// Checker that predicts the codec results from accepted items and compares each result.
`timescale 1ns / 100ps

module hsc_checker
  import hsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  hsc_item_t   item,
  input  logic        result_valid,
  input  logic        result_stall,
  input  hsc_result_t result,
  output int          fail_count,
  output int          outstanding
);

  localparam int unsigned L_COUNT = 19;
  localparam int unsigned N_COUNT = V_COUNT * T_COUNT;

  hsc_result_t expected_codes[$];
  int          results_seen;

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: result %0d: %s", $time, results_seen, what);
    fail_count++;
  endtask

  function automatic logic is_syllable(input int unsigned c);
    return c >= S_BASE && c <= S_LAST;
  endfunction

  function automatic void add_code(input logic [20:0] cp, input logic m, input logic l);
    hsc_result_t r;
    r.code_point = cp;
    r.matched    = m;
    r.last       = l;
    expected_codes.push_back(r);
  endfunction

  function automatic void hangul_outputs(input hsc_item_t it);
    int unsigned a;
    int unsigned b;
    int unsigned s;
    int unsigned t;
    a = 32'(it.code_a);
    b = 32'(it.code_b);
    s = a - S_BASE;
    t = s % T_COUNT;
    case (it.cmd)
      CMD_FULL: begin
        if (!is_syllable(a)) begin
          add_code(21'(a), 1'b0, 1'b1);
        end else begin
          add_code(21'(L_BASE + s / N_COUNT), 1'b1, 1'b0);
          add_code(21'(V_BASE + (s % N_COUNT) / T_COUNT), 1'b1, t == 0);
          if (t != 0) add_code(21'(T_BASE + t), 1'b1, 1'b1);
        end
      end
      CMD_STEP: begin
        if (!is_syllable(a)) begin
          add_code(21'(a), 1'b0, 1'b0);
          add_code(21'd0, 1'b0, 1'b1);
        end else if (t != 0) begin
          add_code(21'(a - t), 1'b1, 1'b0);
          add_code(21'(T_BASE + t), 1'b1, 1'b1);
        end else begin
          add_code(21'(L_BASE + s / N_COUNT), 1'b1, 1'b0);
          add_code(21'(V_BASE + (s % N_COUNT) / T_COUNT), 1'b1, 1'b1);
        end
      end
      CMD_COMPOSE: begin
        if (a >= L_BASE && a < L_BASE + L_COUNT && b >= V_BASE && b < V_BASE + V_COUNT) begin
          add_code(21'(S_BASE + ((a - L_BASE) * V_COUNT + (b - V_BASE)) * T_COUNT),
                   1'b1, 1'b1);
        end else if (is_syllable(a) && t == 0 && b > T_BASE && b < T_BASE + T_COUNT) begin
          add_code(21'(a + b - T_BASE), 1'b1, 1'b1);
        end else begin
          add_code(21'd0, 1'b0, 1'b1);
        end
      end
      default: begin
        add_code(21'd0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  task automatic check_result(input hsc_result_t got);
    hsc_result_t want;
    if (expected_codes.size() == 0) begin
      report_mismatch($sformatf("code point 0x%06h arrived with nothing expected",
                                got.code_point));
    end else begin
      want = expected_codes.pop_front();
      if (got.code_point !== want.code_point)
        report_mismatch($sformatf("code_point 0x%06h, expected 0x%06h",
                                  got.code_point, want.code_point));
      if (got.matched !== want.matched)
        report_mismatch($sformatf("matched %b, expected %b", got.matched, want.matched));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) check_result(result);
      if (item_valid && !item_stall) hangul_outputs(item);
    end
    outstanding <= expected_codes.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the codec testbench: clock, reset, item stimulus, output stalls and the verdict.
`timescale 1ns / 100ps

module tb_top;
  import hsc_pkg::*;

  localparam int unsigned L_COUNT    = 19;
  localparam int unsigned LV_COUNT   = L_COUNT * V_COUNT;
  localparam int unsigned S_COUNT    = LV_COUNT * T_COUNT;
  localparam int          IDLE_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  hsc_item_t   item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  hsc_result_t result;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  int stall_hold = 0;
  bit no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hangul_syllable_codec u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  hsc_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      result_stall <= 1'b1;
      stall_hold <= pick_gap();
    end else begin
      result_stall <= 1'b0;
      stall_hold <= $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input hsc_cmd_t c, input logic [20:0] a, input logic [20:0] b);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item.cmd <= c;
    item.code_a <= a;
    item.code_b <= b;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic send_random();
    int unsigned r;
    int unsigned k;
    hsc_cmd_t    c;
    logic [20:0] a;
    logic [20:0] b;
    a = 21'($urandom_range(0, 21'h1FFFFF));
    b = 21'($urandom_range(0, 21'h1FFFFF));
    r = $urandom_range(0, 99);
    c = r < 35 ? CMD_FULL : r < 60 ? CMD_STEP : r < 95 ? CMD_COMPOSE : CMD_NONE;
    k = $urandom_range(0, 99);
    if (c == CMD_FULL || c == CMD_STEP) begin
      if (k < 70) a = 21'(S_BASE + $urandom_range(0, S_COUNT - 1));
      else if (k < 85) a = 21'($urandom_range(S_BASE - 2, S_LAST + 2));
    end else if (c == CMD_COMPOSE) begin
      if (k < 40) begin
        a = 21'(L_BASE + $urandom_range(0, L_COUNT - 1));
        b = 21'(V_BASE + $urandom_range(0, V_COUNT - 1));
      end else if (k < 75) begin
        a = 21'(S_BASE + T_COUNT * $urandom_range(0, LV_COUNT - 1));
        b = 21'(T_BASE + $urandom_range(1, T_COUNT - 1));
      end else if (k < 85) begin
        a = 21'($urandom_range(L_BASE - 1, L_BASE + L_COUNT));
        b = 21'($urandom_range(V_BASE - 1, V_BASE + V_COUNT));
      end else if (k < 95) begin
        a = 21'(S_BASE + $urandom_range(0, S_COUNT - 1));
        b = 21'($urandom_range(T_BASE - 1, T_BASE + T_COUNT));
      end
    end
    send_item(c, a, b);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Range edges, LV and LVT syllables, points beyond Unicode; step, compose, none.
    send_item(CMD_FULL, 21'h00AC00, 21'h1FFFFF);
    send_item(CMD_FULL, 21'h00D7A3, 21'h000000);
    send_item(CMD_FULL, 21'h00ABFF, 21'h000000);
    send_item(CMD_FULL, 21'h00D7A4, 21'h000000);
    send_item(CMD_FULL, 21'h00AC1B, 21'h000000);
    send_item(CMD_FULL, 21'h000000, 21'h000000);
    send_item(CMD_FULL, 21'h10FFFF, 21'h000000);
    send_item(CMD_FULL, 21'h1FFFFF, 21'h1FFFFF);
    send_item(CMD_STEP, 21'h00AC1C, 21'h000000);
    send_item(CMD_STEP, 21'h00D7A3, 21'h000000);
    send_item(CMD_STEP, 21'h00ABFF, 21'h000000);
    send_item(CMD_STEP, 21'h1FFFFF, 21'h000000);
    send_item(CMD_COMPOSE, L_BASE, V_BASE);
    send_item(CMD_COMPOSE, 21'h001112, 21'h001175);
    send_item(CMD_COMPOSE, 21'h001113, V_BASE);
    send_item(CMD_COMPOSE, L_BASE, 21'h001176);
    send_item(CMD_COMPOSE, 21'h0010FF, 21'h001160);
    send_item(CMD_COMPOSE, 21'h00AC00, 21'h0011A8);
    send_item(CMD_COMPOSE, 21'h00D788, 21'h0011C2);
    send_item(CMD_COMPOSE, 21'h00AC00, T_BASE);
    send_item(CMD_COMPOSE, 21'h00AC01, 21'h0011A8);
    send_item(CMD_COMPOSE, 21'h00AC00, 21'h0011C3);
    send_item(CMD_COMPOSE, 21'h1FFFFF, 21'h1FFFFF);
    send_item(CMD_NONE, 21'h00AC00, 21'h001161);

    item_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);

    for (int i = 0; i < 106; i++) begin
      no_gaps = (i >= 50 && i < 75);
      if (i == 90) begin
        item_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
      end
      send_random();
    end

    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
